>>> rtl/ffs_pkg.sv
// Package for the flipbook frame sequencer: widths, operation and register
// codes, sequencer states and the command/status types of the shared step unit.
// No dependencies.
`default_nettype none
package ffs_pkg;

	localparam int ELAPSED_W = 48;
	localparam int RATE_W    = 16;
	localparam int PROD_W    = ELAPSED_W + RATE_W;
	localparam int FRAC_W    = 24;
	localparam int TARGET_W  = PROD_W - FRAC_W;
	localparam int FRAME_W   = 14;
	localparam int TILE_W    = 7;
	localparam int DELTA_W   = 16;
	localparam int UV_W      = 17;
	localparam int UV_FRAC_W = 16;
	localparam int IDX_W     = FRAME_W + 1;
	localparam int OP_W      = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;
	localparam int DQ_W      = TARGET_W;
	localparam int REM_W     = FRAME_W;
	localparam int OPND_W    = ELAPSED_W;
	localparam int STEP_W    = 6;

	localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
	localparam logic [OP_W-1:0] OP_PLAY      = 3'd1;
	localparam logic [OP_W-1:0] OP_PAUSE     = 3'd2;
	localparam logic [OP_W-1:0] OP_STOP      = 3'd3;
	localparam logic [OP_W-1:0] OP_RESTART   = 3'd4;
	localparam logic [OP_W-1:0] OP_SET_FRAME = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_TILE_COLUMNS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_ROWS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FPS          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE    = 3'd4;

	localparam logic [STEP_W-1:0] MUL_STEPS   = STEP_W'(RATE_W);
	localparam logic [STEP_W-1:0] MOD_STEPS   = STEP_W'(TARGET_W);
	localparam logic [STEP_W-1:0] SPLIT_STEPS = STEP_W'(FRAME_W);
	localparam logic [STEP_W-1:0] EDGE_STEPS  = STEP_W'(UV_FRAC_W);

	localparam logic [UV_W-1:0]      UV_ONE      = 17'h10000;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_MOD,
		S_SPLIT,
		S_COL,
		S_EDGE_GO,
		S_EDGE_RUN,
		S_OUT
	} state_t;

	typedef enum logic {
		MODE_MUL,
		MODE_DIV
	} mode_t;

	typedef struct packed {
		logic               go;
		mode_t              mode;
		logic [REM_W-1:0]   rem;
		logic [DQ_W-1:0]    dq;
		logic [OPND_W-1:0]  opnd;
		logic [STEP_W-1:0]  steps;
	} unit_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage
`default_nettype wire

>>> rtl/ffs_if.sv
// Valid/ready channel interfaces for tick words in and frame words out.
// Depends on ffs_pkg for field widths.
`default_nettype none
interface ffs_tick_if;
	logic                            valid;
	logic                            ready;
	logic [ffs_pkg::OP_W-1:0]        op;
	logic [ffs_pkg::DELTA_W-1:0]     delta_time;
	logic [ffs_pkg::FRAME_W-1:0]     frame_value;

	modport source (output valid, output op, output delta_time, output frame_value,
		input ready);
	modport sink (input valid, input op, input delta_time, input frame_value,
		output ready);
endinterface

interface ffs_frame_if;
	logic                            valid;
	logic                            ready;
	logic [ffs_pkg::FRAME_W-1:0]     frame_index;
	logic                            is_playing;
	logic [ffs_pkg::UV_W-1:0]        uv_min_u;
	logic [ffs_pkg::UV_W-1:0]        uv_min_v;
	logic [ffs_pkg::UV_W-1:0]        uv_max_u;
	logic [ffs_pkg::UV_W-1:0]        uv_max_v;

	modport source (output valid, output frame_index, output is_playing,
		output uv_min_u, output uv_min_v, output uv_max_u, output uv_max_v,
		input ready);
	modport sink (input valid, input frame_index, input is_playing,
		input uv_min_u, input uv_min_v, input uv_max_u, input uv_max_v,
		output ready);
endinterface
`default_nettype wire

>>> rtl/ffs_unit.sv
// Shared step unit: one shift-add multiply step or one restoring divide step
// per cycle, run for a commanded number of steps. Depends on ffs_pkg.
`default_nettype none
module ffs_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ffs_pkg::unit_cmd_t            cmd,
	output ffs_pkg::unit_stat_t                stat,
	output logic [ffs_pkg::PROD_W-1:0]         acc,
	output logic [ffs_pkg::DQ_W-1:0]           dq,
	output logic [ffs_pkg::REM_W-1:0]          rem
);

	logic                              busy_q;
	logic                              done_q;
	logic [ffs_pkg::STEP_W-1:0]        cnt_q;
	ffs_pkg::mode_t                    mode_q;
	logic [ffs_pkg::PROD_W-1:0]        acc_q;
	logic [ffs_pkg::DQ_W-1:0]          dq_q;
	logic [ffs_pkg::REM_W-1:0]         rem_q;
	logic [ffs_pkg::OPND_W-1:0]        opnd_q;

	logic [ffs_pkg::REM_W:0]           part;
	logic [ffs_pkg::REM_W:0]           divisor;
	logic [ffs_pkg::REM_W:0]           diff;
	logic                              fits;
	logic [ffs_pkg::PROD_W-1:0]        addend;
	logic [ffs_pkg::PROD_W-1:0]        acc_next;

	always_comb begin
		part     = {rem_q, dq_q[ffs_pkg::DQ_W-1]};
		divisor  = {1'b0, opnd_q[ffs_pkg::REM_W-1:0]};
		diff     = part - divisor;
		fits     = (part >= divisor);
		addend   = dq_q[ffs_pkg::DQ_W-1] ?
			{{(ffs_pkg::PROD_W-ffs_pkg::OPND_W){1'b0}}, opnd_q} : '0;
		acc_next = {acc_q[ffs_pkg::PROD_W-2:0], 1'b0} + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.go) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= cmd.steps;
		end else begin
			done_q <= busy_q && (cnt_q == ffs_pkg::STEP_W'(1));
			if (busy_q) begin
				cnt_q <= cnt_q - ffs_pkg::STEP_W'(1);
				if (cnt_q == ffs_pkg::STEP_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			mode_q <= cmd.mode;
			acc_q  <= '0;
			dq_q   <= cmd.dq;
			rem_q  <= cmd.rem;
			opnd_q <= cmd.opnd;
		end else if (busy_q) begin
			if (mode_q == ffs_pkg::MODE_MUL) begin
				acc_q <= acc_next;
				dq_q  <= {dq_q[ffs_pkg::DQ_W-2:0], 1'b0};
			end else begin
				// shift in the next dividend bit, subtract where it fits
				rem_q <= fits ? diff[ffs_pkg::REM_W-1:0] : part[ffs_pkg::REM_W-1:0];
				dq_q  <= {dq_q[ffs_pkg::DQ_W-2:0], fits};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign acc       = acc_q;
	assign dq        = dq_q;
	assign rem       = rem_q;

endmodule
`default_nettype wire

>>> rtl/flipbook_frame_sequencer.sv
// Flipbook frame sequencer top level: configuration registers, playback state,
// sequencer and output register. Depends on ffs_pkg, ffs_if and ffs_unit.
//
// Usage: tick_in carries one word per event (tick, play, pause, stop, restart,
// set frame). Control words give no result. A tick that advances playback
// gives one word on frame_out: frame, play flag and the tile's UV rectangle. A
// tick is dropped without result when not playing, when total_frames is below
// 2, when the rate is zero or when delta_time is zero. An advancing tick is
// worked mostly in the shared step unit: 16 multiply steps (elapsed x rate), 40
// divide steps (loop wrap, loop mode only), the 14-step column/row split and a
// divide for each UV edge not already clamped at 1.0, plus the sequencer states
// that split and load the output; a zero tile count skips the split and the
// edges. tick_in.ready is high only while the sequencer is idle, so one tick is
// in work at a time. The result sits in an output register; a new word is taken
// while it waits, and a finished tick holds in its last state until the
// register is free. Reset clears playback (stopped, frame 0, elapsed 0) and
// loads the register defaults: 1x1 sheet, one frame, rate 0, loop on.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// write it only while idle, as the block does not enforce this.
`default_nettype none
module flipbook_frame_sequencer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	ffs_tick_if.sink                               tick_in,
	ffs_frame_if.source                            frame_out,
	input  wire logic                              cfg_we,
	input  wire logic [ffs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ffs_pkg::CFG_W-1:0]         cfg_wdata
);

	// configuration
	logic [ffs_pkg::TILE_W-1:0]    cols_q;
	logic [ffs_pkg::TILE_W-1:0]    rows_q;
	logic [ffs_pkg::FRAME_W-1:0]   total_q;
	logic [ffs_pkg::RATE_W-1:0]    fps_q;
	logic                          loop_q;

	// playback state
	logic [ffs_pkg::ELAPSED_W-1:0] elapsed_q;
	logic [ffs_pkg::FRAME_W-1:0]   frame_q;
	logic                          playing_q;

	ffs_pkg::state_t               state_q;
	ffs_pkg::state_t               state_d;
	logic [1:0]                    edge_q;
	logic [ffs_pkg::TILE_W-1:0]    col_q;
	logic [ffs_pkg::FRAME_W-1:0]   row_q;
	logic [ffs_pkg::UV_W-1:0]      uv_q [4];

	logic                          out_valid_q;
	logic [ffs_pkg::FRAME_W-1:0]   out_frame_q;
	logic                          out_playing_q;
	logic [ffs_pkg::UV_W-1:0]      out_uv_q [4];

	ffs_pkg::unit_cmd_t            cmd;
	ffs_pkg::unit_stat_t           stat;
	logic [ffs_pkg::PROD_W-1:0]    acc_res;
	logic [ffs_pkg::DQ_W-1:0]      dq_res;
	logic [ffs_pkg::REM_W-1:0]     rem_res;

	logic                          accept;
	logic                          skip;
	logic                          out_free;
	logic                          no_tiles;
	logic [ffs_pkg::ELAPSED_W:0]   elapsed_sum;
	logic [ffs_pkg::ELAPSED_W-1:0] elapsed_sat;
	logic [ffs_pkg::TARGET_W-1:0]  target;
	logic [ffs_pkg::IDX_W-1:0]     edge_idx;
	logic [ffs_pkg::TILE_W-1:0]    edge_cnt;
	logic                          edge_full;

	ffs_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.acc    (acc_res),
		.dq     (dq_res),
		.rem    (rem_res)
	);

	always_comb begin
		accept      = tick_in.valid && tick_in.ready;
		skip        = !playing_q || (total_q < ffs_pkg::FRAME_W'(2)) ||
			(fps_q == '0) || (tick_in.delta_time == '0);
		out_free    = !out_valid_q || frame_out.ready;
		no_tiles    = (cols_q == '0) || (rows_q == '0);
		elapsed_sum = {1'b0, elapsed_q} +
			{{(ffs_pkg::ELAPSED_W+1-ffs_pkg::DELTA_W){1'b0}}, tick_in.delta_time};
		elapsed_sat = elapsed_sum[ffs_pkg::ELAPSED_W] ? ffs_pkg::ELAPSED_MAX :
			elapsed_sum[ffs_pkg::ELAPSED_W-1:0];
		target      = acc_res[ffs_pkg::PROD_W-1:ffs_pkg::FRAC_W];

		case (edge_q)
			2'd0: begin
				edge_idx = {{(ffs_pkg::IDX_W-ffs_pkg::TILE_W){1'b0}}, col_q};
				edge_cnt = cols_q;
			end
			2'd1: begin
				edge_idx = {1'b0, row_q};
				edge_cnt = rows_q;
			end
			2'd2: begin
				edge_idx = {{(ffs_pkg::IDX_W-ffs_pkg::TILE_W){1'b0}}, col_q} +
					ffs_pkg::IDX_W'(1);
				edge_cnt = cols_q;
			end
			default: begin
				edge_idx = {1'b0, row_q} + ffs_pkg::IDX_W'(1);
				edge_cnt = rows_q;
			end
		endcase
		// an index at or past the count lands on or beyond 1.0
		edge_full = edge_idx >= {{(ffs_pkg::IDX_W-ffs_pkg::TILE_W){1'b0}}, edge_cnt};
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ffs_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.mode  = ffs_pkg::MODE_DIV;
		tick_in.ready = (state_q == ffs_pkg::S_IDLE);
		unique case (state_q)
			ffs_pkg::S_IDLE: begin
				if (accept && (tick_in.op == ffs_pkg::OP_TICK) && !skip) begin
					cmd.go    = 1'b1;
					cmd.mode  = ffs_pkg::MODE_MUL;
					cmd.opnd  = elapsed_sat;
					cmd.dq    = {fps_q, {(ffs_pkg::DQ_W-ffs_pkg::RATE_W){1'b0}}};
					cmd.steps = ffs_pkg::MUL_STEPS;
					state_d   = ffs_pkg::S_MUL;
				end
			end
			ffs_pkg::S_MUL: begin
				if (stat.done) begin
					if (loop_q) begin
						cmd.go    = 1'b1;
						cmd.dq    = target;
						cmd.opnd  = {{(ffs_pkg::OPND_W-ffs_pkg::FRAME_W){1'b0}}, total_q};
						cmd.steps = ffs_pkg::MOD_STEPS;
						state_d   = ffs_pkg::S_MOD;
					end else begin
						state_d = ffs_pkg::S_SPLIT;
					end
				end
			end
			ffs_pkg::S_MOD: begin
				if (stat.done)
					state_d = ffs_pkg::S_SPLIT;
			end
			ffs_pkg::S_SPLIT: begin
				if (no_tiles) begin
					state_d = ffs_pkg::S_OUT;
				end else begin
					// frame left-aligned so the quotient lands in the low bits
					cmd.go    = 1'b1;
					cmd.dq    = {frame_q, {(ffs_pkg::DQ_W-ffs_pkg::FRAME_W){1'b0}}};
					cmd.opnd  = {{(ffs_pkg::OPND_W-ffs_pkg::TILE_W){1'b0}}, cols_q};
					cmd.steps = ffs_pkg::SPLIT_STEPS;
					state_d   = ffs_pkg::S_COL;
				end
			end
			ffs_pkg::S_COL: begin
				if (stat.done)
					state_d = ffs_pkg::S_EDGE_GO;
			end
			ffs_pkg::S_EDGE_GO: begin
				if (edge_full) begin
					state_d = (edge_q == 2'd3) ? ffs_pkg::S_OUT : ffs_pkg::S_EDGE_GO;
				end else begin
					// idx < count: the index is the first partial remainder
					cmd.go    = 1'b1;
					cmd.rem   = edge_idx[ffs_pkg::REM_W-1:0];
					cmd.opnd  = {{(ffs_pkg::OPND_W-ffs_pkg::TILE_W){1'b0}}, edge_cnt};
					cmd.steps = ffs_pkg::EDGE_STEPS;
					state_d   = ffs_pkg::S_EDGE_RUN;
				end
			end
			ffs_pkg::S_EDGE_RUN: begin
				if (stat.done)
					state_d = (edge_q == 2'd3) ? ffs_pkg::S_OUT : ffs_pkg::S_EDGE_GO;
			end
			ffs_pkg::S_OUT: begin
				if (out_free)
					state_d = ffs_pkg::S_IDLE;
			end
			default: state_d = ffs_pkg::S_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q  <= ffs_pkg::TILE_W'(1);
			rows_q  <= ffs_pkg::TILE_W'(1);
			total_q <= ffs_pkg::FRAME_W'(1);
			fps_q   <= '0;
			loop_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ffs_pkg::REG_TILE_COLUMNS: cols_q  <= cfg_wdata[ffs_pkg::TILE_W-1:0];
				ffs_pkg::REG_TILE_ROWS:    rows_q  <= cfg_wdata[ffs_pkg::TILE_W-1:0];
				ffs_pkg::REG_TOTAL_FRAMES: total_q <= cfg_wdata[ffs_pkg::FRAME_W-1:0];
				ffs_pkg::REG_FPS:          fps_q   <= cfg_wdata[ffs_pkg::RATE_W-1:0];
				ffs_pkg::REG_LOOP_MODE:    loop_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// playback state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q   <= '0;
			frame_q     <= '0;
			playing_q   <= 1'b0;
			edge_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				unique case (tick_in.op)
					ffs_pkg::OP_TICK: begin
						if (!skip)
							elapsed_q <= elapsed_sat;
					end
					ffs_pkg::OP_PLAY:  playing_q <= 1'b1;
					ffs_pkg::OP_PAUSE: playing_q <= 1'b0;
					ffs_pkg::OP_STOP: begin
						playing_q <= 1'b0;
						frame_q   <= '0;
					end
					ffs_pkg::OP_RESTART: begin
						elapsed_q <= '0;
						frame_q   <= '0;
						playing_q <= 1'b1;
					end
					ffs_pkg::OP_SET_FRAME: frame_q <= tick_in.frame_value;
					default: ;
				endcase
			end

			if ((state_q == ffs_pkg::S_MUL) && stat.done && !loop_q) begin
				// hold on the last frame and stop
				if (target >= {{(ffs_pkg::TARGET_W-ffs_pkg::FRAME_W){1'b0}}, total_q}) begin
					frame_q   <= total_q - ffs_pkg::FRAME_W'(1);
					playing_q <= 1'b0;
				end else begin
					frame_q <= target[ffs_pkg::FRAME_W-1:0];
				end
			end
			if ((state_q == ffs_pkg::S_MOD) && stat.done)
				frame_q <= rem_res;

			if (state_q == ffs_pkg::S_SPLIT)
				edge_q <= '0;
			else if ((state_q == ffs_pkg::S_EDGE_GO) && edge_full)
				edge_q <= edge_q + 2'd1;
			else if ((state_q == ffs_pkg::S_EDGE_RUN) && stat.done)
				edge_q <= edge_q + 2'd1;

			if ((state_q == ffs_pkg::S_OUT) && out_free)
				out_valid_q <= 1'b1;
			else if (frame_out.ready)
				out_valid_q <= 1'b0;
		end
	end

	// tile position, edges and output word
	always_ff @(posedge clk) begin
		if ((state_q == ffs_pkg::S_SPLIT) && no_tiles) begin
			uv_q[0] <= '0;
			uv_q[1] <= '0;
			uv_q[2] <= '0;
			uv_q[3] <= '0;
		end
		if ((state_q == ffs_pkg::S_COL) && stat.done) begin
			col_q <= rem_res[ffs_pkg::TILE_W-1:0];
			row_q <= dq_res[ffs_pkg::FRAME_W-1:0];
		end
		if ((state_q == ffs_pkg::S_EDGE_GO) && edge_full)
			uv_q[edge_q] <= ffs_pkg::UV_ONE;
		if ((state_q == ffs_pkg::S_EDGE_RUN) && stat.done)
			uv_q[edge_q] <= {1'b0, dq_res[ffs_pkg::UV_FRAC_W-1:0]};
		if ((state_q == ffs_pkg::S_OUT) && out_free) begin
			out_frame_q   <= frame_q;
			out_playing_q <= playing_q;
			out_uv_q[0]   <= uv_q[0];
			out_uv_q[1]   <= uv_q[1];
			out_uv_q[2]   <= uv_q[2];
			out_uv_q[3]   <= uv_q[3];
		end
	end

	assign frame_out.valid       = out_valid_q;
	assign frame_out.frame_index = out_frame_q;
	assign frame_out.is_playing  = out_playing_q;
	assign frame_out.uv_min_u    = out_uv_q[0];
	assign frame_out.uv_min_v    = out_uv_q[1];
	assign frame_out.uv_max_u    = out_uv_q[2];
	assign frame_out.uv_max_v    = out_uv_q[3];

`ifndef NO_ASSERTIONS
	a_ready_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tick_in.ready |-> !stat.busy)
		else $error("input ready while the step unit is busy");

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (state_q == ffs_pkg::S_MUL) || (state_q == ffs_pkg::S_MOD) ||
			(state_q == ffs_pkg::S_COL) || (state_q == ffs_pkg::S_EDGE_RUN))
		else $error("step unit finished outside a waiting state");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ffs_pkg::S_OUT))
		else $error("output word raised without the sequencer finishing");

	a_loop_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && loop_q) |-> (out_frame_q < total_q))
		else $error("looped frame not below total_frames");
`endif

endmodule
`default_nettype wire
